/* design/mp3s2_pkg.sv */
// Shared types, constants and helper functions for the 3x3 stride-2 max pooling streamer.
// Used by every module of the block; depends on nothing else.

package mp3s2_pkg;

    // Size limits of the plane
    localparam int MAX_IN_WIDTH   = 1024;
    localparam int MAX_IN_HEIGHT  = 4096;
    localparam int MAX_OUT_WIDTH  = 512;
    localparam int MAX_OUT_HEIGHT = 2048;

    // Line stores are split into even and odd output columns
    localparam int BANK_DEPTH = MAX_OUT_WIDTH / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_IN_HEIGHT   = 3'd0,
        CFG_IN_WIDTH    = 3'd1,
        CFG_OUT_HEIGHT  = 3'd2,
        CFG_OUT_WIDTH   = 3'd3,
        CFG_PAD_TOP     = 3'd4,
        CFG_PAD_LEFT    = 3'd5,
        CFG_SIGNED_MODE = 3'd6
    } cfg_index_t;

    // Clamped sizes and output bounds, as the datapath uses them
    typedef struct packed {
        logic [12:0] ih;
        logic [10:0] iw;
        logic [1:0]  ph;
        logic [1:0]  pw;
        logic [11:0] ohb;
        logic [9:0]  owb;
        logic        smode;
    } cfg_t;

    // One output column touched by a pixel
    typedef struct packed {
        logic [8:0] ow;
        logic       last;
    } col_t;

    // One output row completed by a pixel
    typedef struct packed {
        logic [10:0] oh;
        logic        last;
    } row_t;

    // Decoded pixel held between the front end and the line store stage
    typedef struct packed {
        col_t [1:0]      cols;
        logic [1:0][7:0] h;
        logic [1:0]      n_ow;
        row_t [1:0]      rows;
        logic [1:0]      n_oh;
        logic            take_end;
        logic            even_r;
        logic            first_row;
    } item_t;

    // Line store word: overlap row and middle row accumulator of one column
    typedef struct packed {
        logic [7:0] ov;
        logic [7:0] ac;
    } line_t;

    // All results caused by one pixel, indexed [row][column]
    typedef struct packed {
        logic [1:0][1:0][7:0] vals;
        row_t [1:0]           rows;
        col_t [1:0]           cols;
        logic [1:0]           n_oh;
        logic [1:0]           n_ow;
    } res_t;

    function automatic logic [7:0] type_min(input logic smode);
        return {smode, 7'b0};
    endfunction

    // Larger of two pixels, signed or unsigned
    function automatic logic [7:0] pick_max(input logic [7:0] a, input logic [7:0] b,
                                            input logic smode);
        logic [7:0] flip;
        flip = {smode, 7'b0};
        return ((a ^ flip) >= (b ^ flip)) ? a : b;
    endfunction

endpackage

/* design/mp3s2_ram.sv */
// One bank of the column line store: one write and one registered read per cycle.
// Depends on mp3s2_pkg for depth and word type.

module mp3s2_ram (
    input  logic                          clk,
    input  logic                          we,
    input  logic [mp3s2_pkg::BANK_AW-1:0] wr_addr,
    input  mp3s2_pkg::line_t              wr_data,
    input  logic                          rd_en,
    input  logic [mp3s2_pkg::BANK_AW-1:0] rd_addr,
    output mp3s2_pkg::line_t              rd_data
);

    mp3s2_pkg::line_t mem [mp3s2_pkg::BANK_DEPTH];
    mp3s2_pkg::line_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/mp3s2_cfg.sv */
// Configuration registers and the clamped sizes and output bounds derived from them.
// Depends on mp3s2_pkg.

module mp3s2_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [12:0]         cfg_data,
    output mp3s2_pkg::cfg_t     cfg,
    output logic                hold
);

    logic [12:0] in_height_reg;
    logic [10:0] in_width_reg;
    logic [11:0] out_height_reg;
    logic [9:0]  out_width_reg;
    logic [1:0]  pad_top_reg;
    logic [1:0]  pad_left_reg;
    logic        signed_mode_reg;
    logic        hold_reg;

    mp3s2_pkg::cfg_t cfg_reg;
    mp3s2_pkg::cfg_t cfg_next;

    logic [13:0] sum_h;
    logic [13:0] sum_w;
    logic [13:0] bnd_h;
    logic [13:0] bnd_w;
    logic [13:0] lim_h;
    logic [13:0] lim_w;

    // Register writes; block input for one cycle while derived values settle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_height_reg   <= 13'd2;
            in_width_reg    <= 11'd2;
            out_height_reg  <= 12'd1;
            out_width_reg   <= 10'd1;
            pad_top_reg     <= 2'd0;
            pad_left_reg    <= 2'd0;
            signed_mode_reg <= 1'b1;
            hold_reg        <= 1'b0;
        end
        else
        begin
            hold_reg <= cfg_we;
            if (cfg_we)
            begin
                case (mp3s2_pkg::cfg_index_t'(cfg_index))
                    mp3s2_pkg::CFG_IN_HEIGHT:   in_height_reg   <= cfg_data;
                    mp3s2_pkg::CFG_IN_WIDTH:    in_width_reg    <= cfg_data[10:0];
                    mp3s2_pkg::CFG_OUT_HEIGHT:  out_height_reg  <= cfg_data[11:0];
                    mp3s2_pkg::CFG_OUT_WIDTH:   out_width_reg   <= cfg_data[9:0];
                    mp3s2_pkg::CFG_PAD_TOP:     pad_top_reg     <= cfg_data[1:0];
                    mp3s2_pkg::CFG_PAD_LEFT:    pad_left_reg    <= cfg_data[1:0];
                    mp3s2_pkg::CFG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Clamp sizes and pads, then bound the output sizes
    always_comb
    begin
        cfg_next.smode = signed_mode_reg;

        if (in_height_reg == 13'd0)
        begin
            cfg_next.ih = 13'd1;
        end
        else if (in_height_reg > 13'(mp3s2_pkg::MAX_IN_HEIGHT))
        begin
            cfg_next.ih = 13'(mp3s2_pkg::MAX_IN_HEIGHT);
        end
        else
        begin
            cfg_next.ih = in_height_reg;
        end

        if (in_width_reg == 11'd0)
        begin
            cfg_next.iw = 11'd1;
        end
        else if (in_width_reg > 11'(mp3s2_pkg::MAX_IN_WIDTH))
        begin
            cfg_next.iw = 11'(mp3s2_pkg::MAX_IN_WIDTH);
        end
        else
        begin
            cfg_next.iw = in_width_reg;
        end

        cfg_next.ph = (pad_top_reg > 2'd2) ? 2'd2 : pad_top_reg;
        cfg_next.pw = (pad_left_reg > 2'd2) ? 2'd2 : pad_left_reg;

        sum_h = {1'b0, cfg_next.ih} + {11'b0, cfg_next.ph, 1'b0};
        sum_w = {3'b0, cfg_next.iw} + {11'b0, cfg_next.pw, 1'b0};
        bnd_h = (sum_h < 14'd3) ? 14'd0 : ((sum_h - 14'd3) >> 1) + 14'd1;
        bnd_w = (sum_w < 14'd3) ? 14'd0 : ((sum_w - 14'd3) >> 1) + 14'd1;

        lim_h = (bnd_h > {2'b0, out_height_reg}) ? {2'b0, out_height_reg} : bnd_h;
        lim_h = (lim_h > 14'(mp3s2_pkg::MAX_OUT_HEIGHT)) ?
                14'(mp3s2_pkg::MAX_OUT_HEIGHT) : lim_h;
        lim_w = (bnd_w > {4'b0, out_width_reg}) ? {4'b0, out_width_reg} : bnd_w;
        lim_w = (lim_w > 14'(mp3s2_pkg::MAX_OUT_WIDTH)) ?
                14'(mp3s2_pkg::MAX_OUT_WIDTH) : lim_w;

        cfg_next.ohb = lim_h[11:0];
        cfg_next.owb = lim_w[9:0];
    end

    // Hold derived values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ih    <= 13'd2;
            cfg_reg.iw    <= 11'd2;
            cfg_reg.ph    <= 2'd0;
            cfg_reg.pw    <= 2'd0;
            cfg_reg.ohb   <= 12'd0;
            cfg_reg.owb   <= 10'd0;
            cfg_reg.smode <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg  = cfg_reg;
    assign hold = hold_reg;

endmodule

/* design/mp3s2_front.sv */
// Input side: row and column counters, horizontal window maximum, and decode of which
// output rows and columns a pixel completes. Registers the decoded pixel. Uses mp3s2_pkg.

module mp3s2_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mp3s2_pkg::cfg_t                     cfg,
    input  logic [7:0]                          pixel,
    input  logic                                accept,
    input  logic                                adv,
    output logic [1:0][mp3s2_pkg::BANK_AW-1:0]  rd_addr,
    output mp3s2_pkg::item_t                    item,
    output logic                                item_valid
);

    logic [11:0] row_cnt_reg;
    logic [11:0] row_cnt_next;
    logic [9:0]  col_cnt_reg;
    logic [9:0]  col_cnt_next;
    logic [7:0]  hp_reg;
    logic [7:0]  hp_next;
    logic        item_valid_reg;

    mp3s2_pkg::item_t item_reg;
    mp3s2_pkg::item_t item_next;

    logic [11:0] r;
    logic [9:0]  c;
    logic        last_col;
    logic        bottom;
    logic [7:0]  mn;
    logic [7:0]  hp_old;
    logic [7:0]  hmax;
    logic [10:0] relc;
    logic [9:0]  half;
    logic [9:0]  half_m1;
    logic [9:0]  owb_m1;
    logic        a_ok;
    logic        b_ok;
    logic [12:0] relr;
    logic [11:0] rhalf;
    logic [11:0] rhalf_m1;
    logic [11:0] ohb_m1;
    logic        end_ok;
    logic        bot_ok;
    mp3s2_pkg::col_t col_a;
    mp3s2_pkg::col_t col_b;
    mp3s2_pkg::row_t row_e;
    mp3s2_pkg::row_t row_b;
    logic [7:0]  h_b;

    // Decode the current pixel position
    always_comb
    begin
        r = ({1'b0, row_cnt_reg} >= cfg.ih) ? 12'(cfg.ih - 13'd1) : row_cnt_reg;
        c = ({1'b0, col_cnt_reg} >= cfg.iw) ? 10'(cfg.iw - 11'd1) : col_cnt_reg;
        last_col = ({1'b0, c} == (cfg.iw - 11'd1));
        bottom   = ({1'b0, r} == (cfg.ih - 13'd1));

        // horizontal maximum
        mn     = mp3s2_pkg::type_min(cfg.smode);
        hp_old = (c == 10'd0) ? mn : hp_reg;
        hmax   = mp3s2_pkg::pick_max(hp_old, pixel, cfg.smode);

        // output columns completed here
        relc    = {1'b0, c} + {9'b0, cfg.pw};
        hp_next = relc[0] ? hmax : pixel;
        half    = relc[10:1];
        half_m1 = half - 10'd1;
        owb_m1  = cfg.owb - 10'd1;
        a_ok    = !relc[0] && (half != 10'd0) && (half_m1 < cfg.owb);
        b_ok    = last_col && (half < cfg.owb);
        col_a.ow   = half_m1[8:0];
        col_a.last = (half_m1 == owb_m1);
        col_b.ow   = half[8:0];
        col_b.last = (half == owb_m1);
        h_b        = relc[0] ? hmax : pixel;

        // output rows completed on this row
        relr     = {1'b0, r} + {11'b0, cfg.ph};
        rhalf    = relr[12:1];
        rhalf_m1 = rhalf - 12'd1;
        ohb_m1   = cfg.ohb - 12'd1;
        end_ok   = !relr[0] && (rhalf != 12'd0) && (rhalf_m1 < cfg.ohb);
        bot_ok   = bottom && (rhalf < cfg.ohb);
        row_e.oh   = rhalf_m1[10:0];
        row_e.last = (rhalf_m1 == ohb_m1);
        row_b.oh   = rhalf[10:0];
        row_b.last = (rhalf == ohb_m1);

        // pack lists, first valid entry in slot 0
        item_next.cols[0]   = a_ok ? col_a : col_b;
        item_next.h[0]      = a_ok ? hmax : h_b;
        item_next.cols[1]   = col_b;
        item_next.h[1]      = h_b;
        item_next.n_ow      = {1'b0, a_ok} + {1'b0, b_ok};
        item_next.rows[0]   = end_ok ? row_e : row_b;
        item_next.rows[1]   = row_b;
        item_next.n_oh      = {1'b0, end_ok} + {1'b0, bot_ok};
        item_next.take_end  = end_ok;
        item_next.even_r    = !relr[0];
        item_next.first_row = (r == 12'd0);

        // advance counters, wrap at the end of the plane
        if (last_col)
        begin
            col_cnt_next = 10'd0;
            row_cnt_next = bottom ? 12'd0 : r + 12'd1;
        end
        else
        begin
            col_cnt_next = c + 10'd1;
            row_cnt_next = r;
        end
    end

    // Line store read addresses, one per column bank
    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            rd_addr[b] = (item_next.cols[0].ow[0] == 1'(b)) ?
                         item_next.cols[0].ow[8:1] : item_next.cols[1].ow[8:1];
        end
    end

    // Counters and horizontal partial
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg    <= 12'd0;
            col_cnt_reg    <= 10'd0;
            hp_reg         <= mp3s2_pkg::type_min(1'b1);
            item_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                row_cnt_reg    <= row_cnt_next;
                col_cnt_reg    <= col_cnt_next;
                hp_reg         <= hp_next;
                item_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                item_valid_reg <= 1'b0;
            end
        end
    end

    // Decoded pixel register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign item       = item_reg;
    assign item_valid = item_valid_reg;

endmodule

/* design/mp3s2_vert.sv */
// Vertical stage: the two banked column line stores, write forwarding, and the window
// maxima of every result a pixel causes. Uses mp3s2_pkg and mp3s2_ram.

module mp3s2_vert (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mp3s2_pkg::cfg_t                     cfg,
    input  logic                                accept,
    input  logic [1:0][mp3s2_pkg::BANK_AW-1:0]  rd_addr,
    input  mp3s2_pkg::item_t                    item,
    input  logic                                adv,
    output mp3s2_pkg::res_t                     res
);

    mp3s2_pkg::line_t                 rd_data [2];
    mp3s2_pkg::line_t                 wr_data [2];
    logic [mp3s2_pkg::BANK_AW-1:0]    wr_addr [2];
    logic [1:0]                       we;

    logic [1:0]                       fwd_vld_reg;
    logic [mp3s2_pkg::BANK_AW-1:0]    fwd_addr_reg [2];
    mp3s2_pkg::line_t                 fwd_data_reg [2];

    mp3s2_pkg::line_t                 word [2];
    mp3s2_pkg::line_t                 line_new [2];
    logic [7:0]                       mn;
    logic [7:0]                       ov [2];
    logic [7:0]                       ac [2];
    logic [7:0]                       acn [2];
    logic [7:0]                       vend [2];
    logic                             bank;
    logic                             sel0 [2];
    logic                             sel1 [2];

    // Even and odd output column banks
    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        mp3s2_ram u_ram (
            .clk     (clk),
            .we      (we[b]),
            .wr_addr (wr_addr[b]),
            .wr_data (wr_data[b]),
            .rd_en   (accept),
            .rd_addr (rd_addr[b]),
            .rd_data (rd_data[b])
        );
    end

    // Update each touched column and form the window maxima
    always_comb
    begin
        mn = mp3s2_pkg::type_min(cfg.smode);
        for (int j = 0; j < 2; j++)
        begin
            bank    = item.cols[j].ow[0];
            word[j] = rd_data[bank];
            if (fwd_vld_reg[bank] && (fwd_addr_reg[bank] == item.cols[j].ow[8:1]))
            begin
                word[j] = fwd_data_reg[bank];
            end
            ov[j] = item.first_row ? mn : word[j].ov;
            ac[j] = item.first_row ? mn : word[j].ac;

            acn[j]  = mp3s2_pkg::pick_max(ac[j], item.h[j], cfg.smode);
            vend[j] = mp3s2_pkg::pick_max(mp3s2_pkg::pick_max(ov[j], ac[j], cfg.smode),
                                          item.h[j], cfg.smode);
            if (item.even_r)
            begin
                line_new[j].ov = item.h[j];
                line_new[j].ac = mn;
                res.vals[0][j] = item.take_end ? vend[j] : item.h[j];
                res.vals[1][j] = item.h[j];
            end
            else
            begin
                line_new[j].ov = ov[j];
                line_new[j].ac = acn[j];
                res.vals[0][j] = mp3s2_pkg::pick_max(ov[j], acn[j], cfg.smode);
                res.vals[1][j] = res.vals[0][j];
            end
        end
        res.rows = item.rows;
        res.cols = item.cols;
        res.n_oh = item.n_oh;
        res.n_ow = item.n_ow;
    end

    // Write back the columns when the pixel moves on
    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            sel0[b] = (item.n_ow != 2'd0) && (item.cols[0].ow[0] == 1'(b));
            sel1[b] = (item.n_ow == 2'd2) && (item.cols[1].ow[0] == 1'(b));
            we[b]      = adv && (sel0[b] || sel1[b]);
            wr_addr[b] = sel0[b] ? item.cols[0].ow[8:1] : item.cols[1].ow[8:1];
            wr_data[b] = sel0[b] ? line_new[0] : line_new[1];
        end
    end

    // Keep the latest write of each bank for a read issued in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_vld_reg <= 2'b00;
        end
        else
        begin
            for (int b = 0; b < 2; b++)
            begin
                if (we[b])
                begin
                    fwd_vld_reg[b] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < 2; b++)
        begin
            if (we[b])
            begin
                fwd_addr_reg[b] <= wr_addr[b];
                fwd_data_reg[b] <= wr_data[b];
            end
        end
    end

endmodule

/* design/mp3s2_out.sv */
// Output stage: holds the results of one pixel and sends them one beat at a time,
// rows in order and columns ascending within a row. Uses mp3s2_pkg.

module mp3s2_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  mp3s2_pkg::res_t  res,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [31:0]      m_tdata,
    output logic             m_tlast,
    output logic             m_tuser,
    output logic             free
);

    mp3s2_pkg::res_t res_reg;
    logic            vld_reg;
    logic [1:0]      idx_reg;
    logic [1:0]      last_idx_reg;

    logic [2:0]      cnt;
    logic            ri;
    logic            cj;
    logic            at_last;

    // Number of results in the incoming set
    always_comb
    begin
        case (res.n_oh)
            2'd1:    cnt = {1'b0, res.n_ow};
            2'd2:    cnt = {res.n_ow, 1'b0};
            default: cnt = 3'd0;
        endcase
    end

    // Row and column of the current beat
    always_comb
    begin
        if (res_reg.n_ow == 2'd2)
        begin
            ri = idx_reg[1];
            cj = idx_reg[0];
        end
        else
        begin
            ri = idx_reg[0];
            cj = 1'b0;
        end
        at_last = (idx_reg == last_idx_reg);
    end

    // Load a new set or step through the current one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= 1'b0;
            idx_reg      <= 2'd0;
            last_idx_reg <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                vld_reg      <= (cnt != 3'd0);
                idx_reg      <= 2'd0;
                last_idx_reg <= 2'(cnt - 3'd1);
            end
            else if (vld_reg && m_tready)
            begin
                if (at_last)
                begin
                    vld_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign free     = !vld_reg || (m_tready && at_last);
    assign m_tvalid = vld_reg;
    assign m_tdata  = {4'b0, res_reg.cols[cj].ow, res_reg.rows[ri].oh, res_reg.vals[ri][cj]};
    assign m_tlast  = at_last;
    assign m_tuser  = res_reg.rows[ri].last & res_reg.cols[cj].last;

endmodule

/* design/max_pool_3x3_stride2_streamer.sv */
// 3x3 max pooling at stride 2 over one plane of 8-bit pixels, with top and left padding.
// Pixels enter in raster order, one beat each; every output pixel leaves as one beat as soon
// as the last input pixel of its clipped window has arrived, in raster order of the output.
// signed_mode selects int8 or uint8 comparison. A pixel is accepted every cycle while each
// pixel causes at most one result and the output is ready; a pixel that completes n results
// (up to four at the bottom-right corner) holds the input while they are sent, since the
// output sends one beat per cycle while m_tready is high. The first result of a pixel is
// offered after it passes the decoded pixel register, loaded with its line store read on
// acceptance, and then the output register, loaded once the output stage is free. After each
// register write the input is held off for one cycle while the clamped sizes update. Write
// registers only with no beats in flight. Line store contents need no clearing after reset.

module max_pool_3x3_stride2_streamer (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] pixel
    // pooled output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] max_value, [18:8] out_row, [27:19] out_col
    output logic        m_tlast,    // last_of_run
    output logic        m_tuser     // [0] frame_done
);

    mp3s2_pkg::cfg_t                    cfg;
    mp3s2_pkg::item_t                   item;
    mp3s2_pkg::res_t                    res;
    logic [1:0][mp3s2_pkg::BANK_AW-1:0] rd_addr;
    logic                               hold;
    logic                               item_valid;
    logic                               out_free;
    logic                               accept;
    logic                               adv;

    // Move the decoded pixel on when the output stage frees up
    assign adv      = item_valid && out_free;
    assign s_tready = !hold && (!item_valid || out_free);
    assign accept   = s_tvalid && s_tready;

    mp3s2_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .hold      (hold)
    );

    mp3s2_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .pixel      (s_tdata),
        .accept     (accept),
        .adv        (adv),
        .rd_addr    (rd_addr),
        .item       (item),
        .item_valid (item_valid)
    );

    mp3s2_vert u_vert (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .accept  (accept),
        .rd_addr (rd_addr),
        .item    (item),
        .adv     (adv),
        .res     (res)
    );

    mp3s2_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (adv),
        .res      (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .free     (out_free)
    );

endmodule

/* tb/tb.sv */
// Self-checking bench for max_pool_3x3_stride2_streamer: streams pixel planes under many
// geometries and checks every pooled beat against an in-bench model of the pooling.
// Depends on mp3s2_pkg and the streamer RTL only.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUIET_LIMIT   = 3000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_PIXELS = 400;
    localparam int unsigned MAX_REPORTS   = 30;

    // One pooled output beat, fields in tdata order
    typedef struct packed {
        logic [7:0]  max_value;
        logic [10:0] out_row;
        logic [8:0]  out_col;
        logic        last_of_run;
        logic        frame_done;
    } pooled_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [12:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    // Pending pixels and pooled beats still owed by the block
    logic [7:0]  pixel_q[$];
    pooled_t     pooled_q[$];

    int unsigned pixels_pushed    = 0;
    int unsigned pixels_accepted  = 0;
    int unsigned results_checked  = 0;
    int unsigned settings_used    = 0;
    int unsigned errors           = 0;
    int unsigned send_idle_max    = 14;
    int unsigned recv_idle_max    = 14;
    int unsigned gap_cnt          = 0;
    int unsigned stall_cnt        = 0;
    int unsigned quiet_cycles     = 0;

    // Register copies, as written (reset values)
    int unsigned reg_in_height = 2;
    int unsigned reg_in_width  = 2;
    int unsigned reg_out_height = 1;
    int unsigned reg_out_width = 1;
    int unsigned reg_pad_top   = 0;
    int unsigned reg_pad_left  = 0;
    int unsigned reg_signed    = 1;

    // Pooling state: running row maximum, the two line stores, raster position
    logic [7:0]  hpart = 8'h80;
    logic [7:0]  ovl_row[mp3s2_pkg::MAX_OUT_WIDTH];
    logic [7:0]  mid_acc[mp3s2_pkg::MAX_OUT_WIDTH];
    int unsigned row_cnt = 0;
    int unsigned col_cnt = 0;

    max_pool_3x3_stride2_streamer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] larger(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] flip;
        flip = (reg_signed != 0) ? 8'h80 : 8'h00;
        return ((a ^ flip) >= (b ^ flip)) ? a : b;
    endfunction

    // Number of stride-2 windows along one axis
    function automatic int unsigned pool_bound(input int unsigned n, input int unsigned pad);
        int unsigned s;
        s = n + 2 * pad;
        return (s < 3) ? 0 : (s - 3) / 2 + 1;
    endfunction

    // Advance the pooling state by one pixel and queue the beats it completes
    function automatic void pool_pixel(input logic [7:0] px);
        int unsigned ih, iw, ph, pw, ohb, owb, r, c, relc, relr;
        int unsigned n_ow, n_oh, n_all, i, j, k;
        int unsigned ow_l[2];
        int unsigned oh_l[2];
        logic [7:0]  h_l[2];
        logic [7:0]  val[2][2];
        logic [7:0]  mn, hp_old, ov, ac;
        bit          even_r, take_end, take_bot;
        pooled_t     res;

        // clamp the geometry the way the block does
        ih = (reg_in_height == 0) ? 1 :
             (reg_in_height > mp3s2_pkg::MAX_IN_HEIGHT) ? mp3s2_pkg::MAX_IN_HEIGHT :
             reg_in_height;
        iw = (reg_in_width == 0) ? 1 :
             (reg_in_width > mp3s2_pkg::MAX_IN_WIDTH) ? mp3s2_pkg::MAX_IN_WIDTH :
             reg_in_width;
        ph = (reg_pad_top > 2) ? 2 : reg_pad_top;
        pw = (reg_pad_left > 2) ? 2 : reg_pad_left;
        ohb = pool_bound(ih, ph);
        if (ohb > reg_out_height) ohb = reg_out_height;
        if (ohb > mp3s2_pkg::MAX_OUT_HEIGHT) ohb = mp3s2_pkg::MAX_OUT_HEIGHT;
        owb = pool_bound(iw, pw);
        if (owb > reg_out_width) owb = reg_out_width;
        if (owb > mp3s2_pkg::MAX_OUT_WIDTH) owb = mp3s2_pkg::MAX_OUT_WIDTH;
        mn = (reg_signed != 0) ? 8'h80 : 8'h00;

        // a counter past a shrunk size stands on the last row or column
        if (row_cnt >= ih) row_cnt = ih - 1;
        if (col_cnt >= iw) col_cnt = iw - 1;
        r = row_cnt;
        c = col_cnt;
        n_ow = 0;
        n_oh = 0;

        // horizontal: output columns completed by this pixel
        hp_old = (c == 0) ? mn : hpart;
        relc = c + pw;
        if (relc % 2 == 0)
        begin
            if (relc >= 2 && (relc - 2) / 2 < owb)
            begin
                ow_l[n_ow] = (relc - 2) / 2;
                h_l[n_ow] = larger(hp_old, px);
                n_ow++;
            end
            hpart = px;
            if (c == iw - 1 && relc / 2 < owb)
            begin
                ow_l[n_ow] = relc / 2;
                h_l[n_ow] = px;
                n_ow++;
            end
        end
        else
        begin
            hpart = larger(hp_old, px);
            if (c == iw - 1 && (relc - 1) / 2 < owb)
            begin
                ow_l[n_ow] = (relc - 1) / 2;
                h_l[n_ow] = hpart;
                n_ow++;
            end
        end

        // vertical: output rows completed on this input row
        relr = r + ph;
        even_r = (relr % 2 == 0);
        take_end = even_r && relr >= 2 && (relr - 2) / 2 < ohb;
        take_bot = (r == ih - 1) && ((even_r ? relr / 2 : (relr - 1) / 2) < ohb);
        if (take_end)
        begin
            oh_l[n_oh] = (relr - 2) / 2;
            n_oh++;
        end
        if (take_bot)
        begin
            oh_l[n_oh] = even_r ? relr / 2 : (relr - 1) / 2;
            n_oh++;
        end

        for (j = 0; j < n_ow; j++)
        begin
            ov = (r == 0) ? mn : ovl_row[ow_l[j]];
            ac = (r == 0) ? mn : mid_acc[ow_l[j]];
            k = 0;
            if (even_r)
            begin
                if (take_end)
                begin
                    val[k][j] = larger(larger(ov, ac), h_l[j]);
                    k++;
                end
                ov = h_l[j];
                ac = mn;
                if (take_bot) val[k][j] = h_l[j];
            end
            else
            begin
                ac = larger(ac, h_l[j]);
                if (take_bot) val[k][j] = larger(ov, ac);
            end
            ovl_row[ow_l[j]] = ov;
            mid_acc[ow_l[j]] = ac;
        end

        // emit row by row, columns ascending; mark the last beat of this pixel
        n_all = n_oh * n_ow;
        for (i = 0; i < n_oh; i++)
        begin
            for (j = 0; j < n_ow; j++)
            begin
                res.max_value   = val[i][j];
                res.out_row     = oh_l[i][10:0];
                res.out_col     = ow_l[j][8:0];
                res.last_of_run = (i * n_ow + j + 1 == n_all);
                res.frame_done  = (oh_l[i] == ohb - 1) && (ow_l[j] == owb - 1);
                pooled_q.push_back(res);
            end
        end

        // step the raster position, wrapping at the end of the plane
        if (c + 1 >= iw)
        begin
            col_cnt = 0;
            row_cnt = (r + 1 >= ih) ? 0 : r + 1;
        end
        else
        begin
            col_cnt = c + 1;
        end
    endfunction

    // Pixel driver: hold each beat until taken, then idle for the drawn gap
    always @(posedge clk or negedge rst_n)
    begin : pixel_drive
        bit fire;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            gap_cnt  <= 0;
        end
        else
        begin
            fire = s_tvalid && s_tready;
            if (fire)
            begin
                pool_pixel(s_tdata);
                pixels_accepted++;
            end
            if (!s_tvalid || fire)
            begin
                if (gap_cnt != 0)
                begin
                    s_tvalid <= 1'b0;
                    gap_cnt  <= gap_cnt - 1;
                end
                else if (pixel_q.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_q.pop_front();
                    gap_cnt  <= $urandom_range(0, send_idle_max);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each beat with the oldest expectation, then stall at random
    always @(posedge clk or negedge rst_n)
    begin : result_check
        pooled_t     got;
        pooled_t     want;
        int unsigned stall;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            stall_cnt <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            got = {m_tdata[7:0], m_tdata[18:8], m_tdata[27:19], m_tlast, m_tuser};
            results_checked++;
            if (pooled_q.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected beat max=%02h row=%0d col=%0d last=%0b done=%0b",
                             $time, got.max_value, got.out_row, got.out_col,
                             got.last_of_run, got.frame_done);
                errors++;
            end
            else
            begin
                want = pooled_q.pop_front();
                if (got !== want)
                begin
                    if (errors < MAX_REPORTS)
                        $display({"%0t: mismatch expected max=%02h row=%0d col=%0d last=%0b ",
                                  "done=%0b, actual max=%02h row=%0d col=%0d last=%0b done=%0b"},
                                 $time, want.max_value, want.out_row, want.out_col,
                                 want.last_of_run, want.frame_done, got.max_value,
                                 got.out_row, got.out_col, got.last_of_run, got.frame_done);
                    errors++;
                end
            end
            stall = $urandom_range(0, recv_idle_max);
            if (stall != 0)
            begin
                m_tready  <= 1'b0;
                stall_cnt <= stall - 1;
            end
        end
        else if (!m_tready)
        begin
            if (stall_cnt == 0)
                m_tready <= 1'b1;
            else
                stall_cnt <= stall_cnt - 1;
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("%0t: timeout, no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("tb failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_pixel(input logic [7:0] px);
        pixel_q.push_back(px);
        pixels_pushed++;
    endtask

    // Random byte, biased toward the signed and unsigned extremes
    function automatic logic [7:0] rand_pixel();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 3))
                0: v = 8'h00;
                1: v = 8'h7F;
                2: v = 8'h80;
                default: v = 8'hFF;
            endcase
        end
        return v;
    endfunction

    task automatic push_random(input int unsigned n);
        repeat (n) push_pixel(rand_pixel());
    endtask

    // Wait until every pixel is taken and every beat checked, then let the pipe settle
    task automatic drain();
        while (pixels_accepted != pixels_pushed || pooled_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input mp3s2_pkg::cfg_index_t idx, input int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[12:0];
        case (idx)
            mp3s2_pkg::CFG_IN_HEIGHT:   reg_in_height  = val & 32'h1FFF;
            mp3s2_pkg::CFG_IN_WIDTH:    reg_in_width   = val & 32'h7FF;
            mp3s2_pkg::CFG_OUT_HEIGHT:  reg_out_height = val & 32'hFFF;
            mp3s2_pkg::CFG_OUT_WIDTH:   reg_out_width  = val & 32'h3FF;
            mp3s2_pkg::CFG_PAD_TOP:     reg_pad_top    = val & 32'h3;
            mp3s2_pkg::CFG_PAD_LEFT:    reg_pad_left   = val & 32'h3;
            mp3s2_pkg::CFG_SIGNED_MODE: reg_signed     = val & 32'h1;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input int unsigned ih, input int unsigned iw,
                             input int unsigned oh, input int unsigned ow,
                             input int unsigned pt, input int unsigned pl,
                             input int unsigned sm);
        write_reg(mp3s2_pkg::CFG_IN_HEIGHT, ih);
        write_reg(mp3s2_pkg::CFG_IN_WIDTH, iw);
        write_reg(mp3s2_pkg::CFG_OUT_HEIGHT, oh);
        write_reg(mp3s2_pkg::CFG_OUT_WIDTH, ow);
        write_reg(mp3s2_pkg::CFG_PAD_TOP, pt);
        write_reg(mp3s2_pkg::CFG_PAD_LEFT, pl);
        write_reg(mp3s2_pkg::CFG_SIGNED_MODE, sm);
        settings_used++;
    endtask

    initial
    begin : stimulus
        int unsigned ih, iw, oh, ow, pt, pl, sm, n_pix, cut, reps, random_pixels;
        bit          split;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: 2x2 plane without padding has no full window
        push_pixel(8'h80);
        push_pixel(8'h7F);
        push_pixel(8'hFF);
        push_pixel(8'h00);
        drain();

        // 3x3 unsigned, pads written as 3 clamp to 2; the corner pixel completes four beats
        configure(3, 3, 3, 3, 3, 3, 0);
        push_pixel(8'h00);
        push_pixel(8'hFF);
        push_pixel(8'h7F);
        push_pixel(8'h80);
        push_pixel(8'h01);
        push_pixel(8'hFE);
        push_pixel(8'h55);
        push_pixel(8'hAA);
        push_pixel(8'h00);
        drain();

        // zero sizes clamp to one pixel: every pixel is a whole plane
        configure(0, 0, 1, 1, 1, 1, 1);
        push_pixel(8'h80);
        push_pixel(8'h7F);
        push_pixel(8'h00);
        drain();

        // shrink the plane mid-row: counters past the new size stand on the last row/column
        configure(8, 12, 3, 5, 0, 0, $urandom_range(0, 1));
        push_random(4 * 12 + 9);
        drain();
        write_reg(mp3s2_pkg::CFG_IN_WIDTH, 6);
        write_reg(mp3s2_pkg::CFG_IN_HEIGHT, 3);
        push_random(1 + 3 * 6);
        drain();

        // random geometries; the first plane pauses mid-plane until drained if it has over one pixel
        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS)
        begin
            ih = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 9);
            iw = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 12);
            pt = $urandom_range(0, 3);
            pl = $urandom_range(0, 3);
            oh = pool_bound((ih == 0) ? 1 : ih, (pt > 2) ? 2 : pt);
            ow = pool_bound((iw == 0) ? 1 : iw, (pl > 2) ? 2 : pl);
            if ($urandom_range(0, 3) == 0) oh = $urandom_range(0, oh + 2);
            if ($urandom_range(0, 3) == 0) ow = $urandom_range(0, ow + 2);
            sm = $urandom_range(0, 1);
            configure(ih, iw, oh, ow, pt, pl, sm);
            send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
            recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
            n_pix = ((ih == 0) ? 1 : ih) * ((iw == 0) ? 1 : iw);
            reps = $urandom_range(1, 2);
            split = (random_pixels == 0) || ($urandom_range(0, 2) == 0);
            if (split && n_pix > 1)
            begin
                cut = $urandom_range(1, n_pix - 1);
                push_random(cut);
                drain();
                push_random(n_pix * reps - cut);
            end
            else
            begin
                push_random(n_pix * reps);
            end
            drain();
            random_pixels += n_pix * reps;
        end

        $display("ran %0d register settings and %0d pixels, %0d pooled beats checked",
                 settings_used, pixels_accepted, results_checked);
        $display("planes up to 9x12 with size and pad clamps, mid-plane shrink, both modes");
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
